// ===== design/adpi_pkg.sv =====
// Package for the ARM data-processing immediate ALU.
// Holds widths, opcode and command codes, the queue entry and result types.
// No dependencies.
package adpi_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 4;
    localparam int NUM_REGS        = 16;
    localparam int FLAGS_W         = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [3:0] OPC_AND = 4'h0;
    localparam logic [3:0] OPC_SUB = 4'h2;
    localparam logic [3:0] OPC_RSB = 4'h3;
    localparam logic [3:0] OPC_ADD = 4'h4;
    localparam logic [3:0] OPC_TST = 4'h8;
    localparam logic [3:0] OPC_TEQ = 4'h9;
    localparam logic [3:0] OPC_CMP = 4'hA;
    localparam logic [3:0] OPC_ORR = 4'hC;
    localparam logic [3:0] OPC_MOV = 4'hD;
    localparam logic [3:0] OPC_BIC = 4'hE;

    localparam logic [IDX_W-1:0] PC_IDX = 4'hF;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_OPCODE = 2'd1,
        ERR_CMP_RD = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        ALU_AND,
        ALU_EOR,
        ALU_ORR,
        ALU_MOV,
        ALU_BIC,
        ALU_SUB,
        ALU_RSB,
        ALU_ADD
    } t_alu_op;

    typedef enum logic [1:0] {
        K_EXEC,
        K_WRITE,
        K_READ,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_alu_op           alu_op;
        logic              set_flags;
        logic              writes;
        logic              add_pc;
        logic [IDX_W-1:0]  rn;
        logic [IDX_W-1:0]  rd;
        logic [DATA_W-1:0] operand;
        t_err              err;
    } t_uop;

    typedef struct packed {
        logic               writes_register;
        logic [IDX_W-1:0]   destination_index;
        logic [DATA_W-1:0]  result_value;
        logic [FLAGS_W-1:0] flags_now;
        t_err               error_code;
    } t_result;

endpackage

// ===== design/adpi_if.sv =====
// Channel interfaces: command beats in, result beats out.
// Depends on adpi_pkg.
interface adpi_in_if import adpi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [DATA_W-1:0] instruction_word;
    logic [IDX_W-1:0]  register_index;
    logic [DATA_W-1:0] register_data;

    modport source (output valid, command, instruction_word, register_index, register_data,
                    input ready);
    modport sink   (input valid, command, instruction_word, register_index, register_data,
                    output ready);
endinterface

interface adpi_out_if import adpi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               writes_register;
    logic [IDX_W-1:0]   destination_index;
    logic [DATA_W-1:0]  result_value;
    logic [FLAGS_W-1:0] flags_now;
    logic [1:0]         error_code;

    modport source (output valid, writes_register, destination_index, result_value,
                    flags_now, error_code, input ready);
    modport sink   (input valid, writes_register, destination_index, result_value,
                    flags_now, error_code, output ready);
endinterface

// ===== design/adpi_front.sv =====
// Front end: accepts command beats, decodes the instruction word and
// rotates the immediate, producing one queue entry per beat. Depends on adpi_pkg.
module adpi_front import adpi_pkg::*; (
    adpi_in_if.sink i_cmd,
    input  logic    i_push_ready,
    output logic    o_push_valid,
    output t_uop    o_push_uop
);

    logic [3:0]          opc;
    logic [IDX_W-1:0]    rn;
    logic [IDX_W-1:0]    rd;
    logic [2*DATA_W-1:0] rot_dbl;
    logic [DATA_W-1:0]   imm;
    logic                is_cmp;
    t_alu_op             alu;
    t_err                err;

    assign i_cmd.ready  = i_push_ready;
    assign o_push_valid = i_cmd.valid;

    assign opc     = i_cmd.instruction_word[24:21];
    assign rn      = i_cmd.instruction_word[19:16];
    assign rd      = i_cmd.instruction_word[15:12];
    assign rot_dbl = {2{24'd0, i_cmd.instruction_word[7:0]}}
                     >> {i_cmd.instruction_word[11:8], 1'b0};
    assign imm     = rot_dbl[DATA_W-1:0];

    always_comb begin
        is_cmp = 1'b0;
        alu    = ALU_AND;
        err    = ERR_OK;
        unique case (opc)
            OPC_AND: alu = ALU_AND;
            OPC_SUB: alu = ALU_SUB;
            OPC_RSB: alu = ALU_RSB;
            OPC_ADD: alu = ALU_ADD;
            OPC_TST: begin
                alu    = ALU_AND;
                is_cmp = 1'b1;
            end
            OPC_TEQ: begin
                alu    = ALU_EOR;
                is_cmp = 1'b1;
            end
            OPC_CMP: begin
                alu    = ALU_SUB;
                is_cmp = 1'b1;
            end
            OPC_ORR: alu = ALU_ORR;
            OPC_MOV: alu = ALU_MOV;
            OPC_BIC: alu = ALU_BIC;
            default: err = ERR_OPCODE;
        endcase
        if (is_cmp && rd != '0) begin
            err = ERR_CMP_RD;
        end
    end

    always_comb begin
        o_push_uop           = '0;
        o_push_uop.alu_op    = alu;
        o_push_uop.err       = ERR_OK;
        unique case (t_cmd'(i_cmd.command))
            CMD_EXEC: begin
                o_push_uop.kind      = (err == ERR_OK) ? K_EXEC : K_NONE;
                o_push_uop.err       = err;
                o_push_uop.set_flags = i_cmd.instruction_word[20] | is_cmp;
                o_push_uop.writes    = ~is_cmp;
                o_push_uop.add_pc    = (opc == OPC_ADD) && (rn == PC_IDX);
                o_push_uop.rn        = rn;
                o_push_uop.rd        = rd;
                o_push_uop.operand   = imm;
            end
            CMD_WRITE: begin
                o_push_uop.kind    = K_WRITE;
                o_push_uop.rn      = i_cmd.register_index;
                o_push_uop.rd      = i_cmd.register_index;
                o_push_uop.operand = i_cmd.register_data;
            end
            CMD_READ: begin
                o_push_uop.kind = K_READ;
                o_push_uop.rn   = i_cmd.register_index;
                o_push_uop.rd   = i_cmd.register_index;
            end
            CMD_NONE: begin
                o_push_uop.kind = K_NONE;
            end
        endcase
    end

endmodule

// ===== design/adpi_queue.sv =====
// Small FIFO of decoded entries between front and back ends.
// Depends on adpi_pkg.
module adpi_queue import adpi_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_uop i_push_uop,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_uop o_pop_uop,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_uop             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_uop    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_uop;
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with pointers apart");

endmodule

// ===== design/adpi_back.sv =====
// Back end: register file, NZCV flags and ALU; executes one queue entry per cycle into
// an output register while it is empty or read out. Depends on adpi_pkg, adpi_if.
module adpi_back import adpi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_uop_valid,
    input  t_uop       i_uop,
    output logic       o_pop,
    adpi_out_if.source o_res
);

    logic [DATA_W-1:0]  r_regs [NUM_REGS];
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               fire;
    logic [DATA_W-1:0]  a, x, y, yn, alu_r;
    logic [DATA_W:0]    sum;
    logic               is_sub, is_arith, ovf;
    logic               wr_en;
    logic [DATA_W-1:0]  wr_data;

    assign fire  = i_uop_valid && (!r_out_valid || o_res.ready);
    assign o_pop = fire;

    assign a        = r_regs[i_uop.rn] + (i_uop.add_pc ? DATA_W'(4) : '0);
    assign is_sub   = (i_uop.alu_op == ALU_SUB) || (i_uop.alu_op == ALU_RSB);
    assign is_arith = is_sub || (i_uop.alu_op == ALU_ADD);
    assign x        = (i_uop.alu_op == ALU_RSB) ? i_uop.operand : a;
    assign y        = (i_uop.alu_op == ALU_RSB) ? a : i_uop.operand;
    assign yn       = is_sub ? ~y : y;
    assign sum      = {1'b0, x} + {1'b0, yn} + {{DATA_W{1'b0}}, is_sub};
    assign ovf      = (x[DATA_W-1] == yn[DATA_W-1]) && (sum[DATA_W-1] != x[DATA_W-1]);

    always_comb begin
        unique case (i_uop.alu_op)
            ALU_AND: alu_r = a & i_uop.operand;
            ALU_EOR: alu_r = a ^ i_uop.operand;
            ALU_ORR: alu_r = a | i_uop.operand;
            ALU_MOV: alu_r = i_uop.operand;
            ALU_BIC: alu_r = a & ~i_uop.operand;
            ALU_SUB, ALU_RSB, ALU_ADD: alu_r = sum[DATA_W-1:0];
        endcase
    end

    always_comb begin
        n_flags = r_flags;
        wr_en   = 1'b0;
        wr_data = i_uop.operand;
        if (fire) begin
            unique case (i_uop.kind)
                K_EXEC: begin
                    wr_en   = i_uop.writes;
                    wr_data = alu_r;
                    if (i_uop.set_flags) begin
                        n_flags = is_arith
                            ? {alu_r[DATA_W-1], alu_r == '0, sum[DATA_W], ovf}
                            : {alu_r[DATA_W-1], alu_r == '0, r_flags[1:0]};
                    end
                end
                K_WRITE: wr_en = 1'b1;
                K_READ, K_NONE: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (fire) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.flags_now  = n_flags;
            n_out.error_code = i_uop.err;
            unique case (i_uop.kind)
                K_EXEC: begin
                    n_out.writes_register   = i_uop.writes;
                    n_out.destination_index = i_uop.writes ? i_uop.rd : '0;
                    n_out.result_value      = alu_r;
                end
                K_WRITE: begin
                    n_out.destination_index = i_uop.rd;
                    n_out.result_value      = i_uop.operand;
                end
                K_READ: begin
                    n_out.destination_index = i_uop.rd;
                    n_out.result_value      = r_regs[i_uop.rn];
                end
                K_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_regs[i_uop.rd] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.writes_register   = r_out.writes_register;
    assign o_res.destination_index = r_out.destination_index;
    assign o_res.result_value      = r_out.result_value;
    assign o_res.flags_now         = r_out.flags_now;
    assign o_res.error_code        = r_out.error_code;

    a_flags_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_flags))
        else $error("flags changed without an executed entry");

    a_flags_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_uop.kind == K_NONE |=> $stable(r_flags))
        else $error("rejected entry changed flags");

    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid && r_out.flags_now == r_flags)
        else $error("executed entry missing from output register");

endmodule

// ===== design/arm_data_processing_immediate_alu.sv =====
// Top level of the ARM data-processing immediate ALU: front decode, entry
// queue, back end execution. Depends on adpi_pkg, adpi_if and the adpi_* modules.
//
//   channel  dir  beat
//   i_cmd    in   command, instruction_word, register_index, register_data
//   o_res    out  writes_register, destination_index, result_value, flags_now, error_code
//
// One beat per cycle sustained while o_res takes results; a result is registered in the
// queue entry written when its command is taken, then in the output register. The back
// end ALU with its register file executes one entry a cycle unless o_res stalls. Synchronous
// active-low reset clears registers, flags and queue. A stalled o_res holds its beat while the
// queue keeps taking commands until it fills.
module arm_data_processing_immediate_alu import adpi_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    adpi_in_if.sink    i_cmd,
    adpi_out_if.source o_res
);

    logic push_valid, push_ready, pop_valid, pop;
    t_uop push_uop, pop_uop;

    adpi_front u_front (
        .i_cmd        (i_cmd),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_uop   (push_uop)
    );

    adpi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_uop   (push_uop),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_uop    (pop_uop),
        .i_pop        (pop)
    );

    adpi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (pop_valid),
        .i_uop       (pop_uop),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

// ===== bench/arm_data_processing_immediate_alu_test.sv =====
`timescale 1ns / 1ps
// Testbench for arm_data_processing_immediate_alu: directed and random command beats,
// each result checked against a cycle-free model of the register file and NZCV flags.
// Depends on adpi_pkg, adpi_if and the design under design/.
module arm_data_processing_immediate_alu_test;
    import adpi_pkg::*;

    localparam int         STALL_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         RANDOM_ITEMS  = 1000;
    localparam logic [3:0] OPC_UNDEF_LO  = 4'h1;
    localparam logic [3:0] OPC_UNDEF_HI  = 4'hF;
    localparam int         FLAG_N        = 3;
    localparam int         FLAG_Z        = 2;
    localparam int         FLAG_C        = 1;
    localparam int         FLAG_V        = 0;

    logic i_clk;
    logic i_rst_n;

    adpi_in_if  cmd_ch ();
    adpi_out_if res_ch ();

    arm_data_processing_immediate_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    logic [DATA_W-1:0]  reg_model [NUM_REGS];
    logic [FLAGS_W-1:0] nzcv_model;
    t_result            pending_results [$];
    int                 err_count;
    int                 stall_cycles = 0;
    bit                 idle_en;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // NZCV helpers
    function automatic logic [3:0] nz_of(logic [31:0] r);
        logic [3:0] f;
        f = '0;
        f[FLAG_N] = r[31];
        f[FLAG_Z] = (r == '0);
        return f;
    endfunction

    function automatic logic [3:0] add_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
        logic [3:0]  f;
        logic [32:0] sum;
        logic [31:0] v;
        sum = {1'b0, a} + {1'b0, b};
        v = ~(a ^ b) & (a ^ r);
        f = nz_of(r);
        f[FLAG_C] = sum[32];
        f[FLAG_V] = v[31];
        return f;
    endfunction

    function automatic logic [3:0] sub_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
        logic [3:0]  f;
        logic [31:0] v;
        v = (a ^ b) & (a ^ r);
        f = nz_of(r);
        f[FLAG_C] = (a >= b);
        f[FLAG_V] = v[31];
        return f;
    endfunction

    function automatic logic [3:0] logic_flags(logic [31:0] r);
        logic [3:0] f;
        f = nz_of(r);
        f[FLAG_C] = nzcv_model[FLAG_C];
        f[FLAG_V] = nzcv_model[FLAG_V];
        return f;
    endfunction

    function automatic t_result predict_alu_result(logic [1:0] cmd, logic [31:0] word,
                                                   logic [3:0] idx, logic [31:0] data);
        t_result     res;
        logic [3:0]  opc, rn, rd;
        logic        s_bit, writes;
        logic [5:0]  shamt;
        logic [63:0] imm2;
        logic [31:0] imm, a, r;
        res = '0;
        res.error_code = ERR_OK;
        case (cmd)
            CMD_EXEC: begin
                opc    = word[24:21];
                s_bit  = word[20];
                rn     = word[19:16];
                rd     = word[15:12];
                shamt  = {1'b0, word[11:8], 1'b0};
                imm2   = {24'd0, word[7:0], 24'd0, word[7:0]} >> shamt;
                imm    = imm2[31:0];
                a      = reg_model[rn];
                r      = '0;
                writes = 1'b1;
                if ((opc == OPC_TST || opc == OPC_TEQ || opc == OPC_CMP) && rd != '0) begin
                    res.error_code = ERR_CMP_RD;
                end else begin
                    case (opc)
                        OPC_AND: begin
                            r = a & imm;
                            if (s_bit) nzcv_model = logic_flags(r);
                        end
                        OPC_SUB: begin
                            r = a - imm;
                            if (s_bit) nzcv_model = sub_flags(a, imm, r);
                        end
                        OPC_RSB: begin
                            r = imm - a;
                            if (s_bit) nzcv_model = sub_flags(imm, a, r);
                        end
                        OPC_ADD: begin
                            if (rn == PC_IDX) a = a + 32'd4;
                            r = a + imm;
                            if (s_bit) nzcv_model = add_flags(a, imm, r);
                        end
                        OPC_TST: begin
                            r = a & imm;
                            nzcv_model = logic_flags(r);
                            writes = 1'b0;
                        end
                        OPC_TEQ: begin
                            r = a ^ imm;
                            nzcv_model = logic_flags(r);
                            writes = 1'b0;
                        end
                        OPC_CMP: begin
                            r = a - imm;
                            nzcv_model = sub_flags(a, imm, r);
                            writes = 1'b0;
                        end
                        OPC_ORR: begin
                            r = a | imm;
                            if (s_bit) nzcv_model = logic_flags(r);
                        end
                        OPC_MOV: begin
                            r = imm;
                            if (s_bit) nzcv_model = logic_flags(r);
                        end
                        OPC_BIC: begin
                            r = a & ~imm;
                            if (s_bit) nzcv_model = logic_flags(r);
                        end
                        default: begin
                            res.error_code = ERR_OPCODE;
                            writes = 1'b0;
                        end
                    endcase
                    if (res.error_code == ERR_OK) begin
                        res.result_value = r;
                        if (writes) begin
                            reg_model[rd] = r;
                            res.writes_register = 1'b1;
                            res.destination_index = rd;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                reg_model[idx] = data;
                res.destination_index = idx;
                res.result_value = data;
            end
            CMD_READ: begin
                res.destination_index = idx;
                res.result_value = reg_model[idx];
            end
            default: ;
        endcase
        res.flags_now = nzcv_model;
        return res;
    endfunction

    function automatic logic [31:0] dp_word(logic [3:0] opc, logic s_bit, logic [3:0] rn,
                                            logic [3:0] rd, logic [3:0] rot, logic [7:0] imm);
        return {7'd0, opc, s_bit, rn, rd, rot, imm};
    endfunction

    function automatic bit is_supported(logic [3:0] opc);
        case (opc)
            OPC_AND, OPC_SUB, OPC_RSB, OPC_ADD, OPC_TST,
            OPC_TEQ, OPC_CMP, OPC_ORR, OPC_MOV, OPC_BIC: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Send one beat; returns in the time step of the accepting edge, valid left high.
    task automatic send_beat(logic [1:0] cmd, logic [31:0] word, logic [3:0] idx,
                             logic [31:0] data);
        while (idle_en && $urandom_range(99) < 35) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.command          <= cmd;
        cmd_ch.instruction_word <= word;
        cmd_ch.register_index   <= idx;
        cmd_ch.register_data    <= data;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_alu_result(cmd, word, idx, data));
    endtask

    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_register_access();
        send_beat(CMD_WRITE, $urandom, 4'd0, 32'hFFFF_FFFF);
        send_beat(CMD_WRITE, $urandom, PC_IDX, 32'hFFFF_FFFC);
        send_beat(CMD_WRITE, $urandom, 4'd7, 32'h8000_0000);
        send_beat(CMD_WRITE, $urandom, 4'd3, 32'h7FFF_FFFF);
        send_beat(CMD_READ, $urandom, PC_IDX, $urandom);
        send_beat(CMD_READ, $urandom, 4'd0, $urandom);
        send_beat(CMD_READ, $urandom, 4'd1, $urandom);
    endtask

    task automatic test_operations();
        send_beat(CMD_EXEC, dp_word(OPC_AND, 1'b1, 4'd0, 4'd1, 4'd0, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_SUB, 1'b1, 4'd3, 4'd2, 4'd1, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_RSB, 1'b1, 4'd7, 4'd2, 4'd0, 8'h00),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_ADD, 1'b1, 4'd0, 4'd3, 4'd0, 8'h01),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_TST, 1'b0, 4'd1, 4'd0, 4'd0, 8'h00),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_TEQ, 1'b0, 4'd0, 4'd0, 4'd4, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_CMP, 1'b1, 4'd7, 4'd0, 4'd15, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_ORR, 1'b0, 4'd1, 4'd4, 4'd1, 8'h80),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_MOV, 1'b1, 4'd9, 4'd5, 4'd15, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_BIC, 1'b1, 4'd0, 4'd6, 4'd0, 8'hFF),
                  4'($urandom), $urandom);
    endtask

    task automatic test_special_cases();
        send_beat(CMD_EXEC, dp_word(OPC_ADD, 1'b1, PC_IDX, 4'd8, 4'd0, 8'h00),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_ADD, 1'b0, PC_IDX, 4'd8, 4'd0, 8'h01),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_UNDEF_LO, 1'b1, 4'd0, 4'd2, 4'd0, 8'h12),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_UNDEF_HI, 1'b1, 4'd7, 4'd2, 4'd3, 8'h34),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_CMP, 1'b1, 4'd0, 4'd9, 4'd0, 8'h01),
                  4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_TST, 1'b1, 4'd0, 4'hF, 4'd0, 8'hFF),
                  4'($urandom), $urandom);
        send_beat(CMD_NONE, $urandom, 4'($urandom), $urandom);
        send_beat(CMD_EXEC, dp_word(OPC_MOV, 1'b1, 4'd0, 4'd10, 4'd0, 8'h00) | 32'hFE00_0000,
                  4'($urandom), $urandom);
    endtask

    task automatic test_random_mix();
        logic [31:0] w;
        logic [31:0] d;
        logic [3:0]  opc;
        int          pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en = !(n >= 300 && n < 450);
            if (n == 600) wait_for_drain();
            pick = $urandom_range(99);
            if (pick < 60) begin
                w = $urandom;
                if ($urandom_range(9) == 0) begin
                    do opc = 4'($urandom_range(15)); while (is_supported(opc));
                end else begin
                    do opc = 4'($urandom_range(15)); while (!is_supported(opc));
                end
                w[24:21] = opc;
                if ((opc == OPC_TST || opc == OPC_TEQ || opc == OPC_CMP) &&
                    $urandom_range(4) != 0) w[15:12] = '0;
                if ($urandom_range(3) == 0) w[11:8] = '0;
                send_beat(CMD_EXEC, w, 4'($urandom), $urandom);
            end else if (pick < 78) begin
                case ($urandom_range(7))
                    0:       d = '0;
                    1:       d = '1;
                    2:       d = 32'h8000_0000;
                    3:       d = 32'h7FFF_FFFF;
                    default: d = $urandom;
                endcase
                send_beat(CMD_WRITE, $urandom, 4'($urandom), d);
            end else if (pick < 96) begin
                send_beat(CMD_READ, $urandom, 4'($urandom), $urandom);
            end else begin
                send_beat(CMD_NONE, $urandom, 4'($urandom), $urandom);
            end
        end
        idle_en = 1'b1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", res_ch.result_value, '0);
            end else begin
                exp_res = pending_results.pop_front();
                if (res_ch.writes_register !== exp_res.writes_register)
                    report_mismatch("writes_register", 32'(res_ch.writes_register),
                                    32'(exp_res.writes_register));
                if (res_ch.destination_index !== exp_res.destination_index)
                    report_mismatch("destination_index", 32'(res_ch.destination_index),
                                    32'(exp_res.destination_index));
                if (res_ch.result_value !== exp_res.result_value)
                    report_mismatch("result_value", res_ch.result_value, exp_res.result_value);
                if (res_ch.flags_now !== exp_res.flags_now)
                    report_mismatch("flags_now", 32'(res_ch.flags_now),
                                    32'(exp_res.flags_now));
                if (res_ch.error_code !== exp_res.error_code)
                    report_mismatch("error_code", 32'(res_ch.error_code),
                                    32'(exp_res.error_code));
            end
        end
    end

    // result backpressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= idle_en ? ($urandom_range(99) >= 35) : 1'b1;
        end
    end

    // watchdog on beats in either direction
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        err_count    = 0;
        idle_en      = 1'b1;
        nzcv_model   = '0;
        for (int i = 0; i < NUM_REGS; i++) reg_model[i] = '0;
        i_rst_n                 <= 1'b0;
        cmd_ch.valid            <= 1'b0;
        cmd_ch.command          <= CMD_EXEC;
        cmd_ch.instruction_word <= '0;
        cmd_ch.register_index   <= '0;
        cmd_ch.register_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_operations();
        test_special_cases();
        test_random_mix();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), '0);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
